// ----- hdl/message_type_sniffer_ring_assert.svh -----
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef MESSAGE_TYPE_SNIFFER_RING_ASSERT_SVH
`define MESSAGE_TYPE_SNIFFER_RING_ASSERT_SVH

// same-cycle implication
`define MTSR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("message_type_sniffer_ring assertion failed");

// next-cycle implication
`define MTSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("message_type_sniffer_ring assertion failed");

`endif

// ----- hdl/mtsr_pkg.sv -----
`default_nettype none

package mtsr_pkg;

  localparam int RING_DEPTH_DEF = 16;
  localparam int OP_FIFO_DEPTH  = 4;
  localparam int OUT_FIFO_DEPTH = 4;
  localparam int SEQ_W          = 32;
  localparam int TIME_W         = 63;
  localparam int BYTE_W         = 8;

  typedef enum logic [2:0] {
    MT_UNKNOWN = 3'd0,
    MT_HELLO   = 3'd1,
    MT_ADV     = 3'd2,
    MT_SYNC    = 3'd3,
    MT_BIS     = 3'd4,
    MT_LOG     = 3'd5
  } msg_type_t;

  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [BYTE_W-1:0]   line_byte;
    logic                line_last;
    logic [TIME_W-1:0]   arrival_time;
    logic [SEQ_W-1:0]    query_seq;
  } in_word_t;

  typedef struct packed {
    logic                hit;
    msg_type_t           message_type;
    logic [SEQ_W-1:0]    message_seq;
    logic [TIME_W-1:0]   message_time;
    logic [SEQ_W-1:0]    newest_seq;
  } out_word_t;

  // operation handed from the scanner to the ring
  typedef struct packed {
    logic                is_query;
    msg_type_t           msg_type;
    logic [TIME_W-1:0]   arrival_time;
    logic [SEQ_W-1:0]    query_seq;
  } op_t;

endpackage

`default_nettype wire

// ----- hdl/message_type_sniffer_ring.sv -----
// a query's result passes through the op queue, the ring read stage and the result queue on its way to the result ports
// throughput: one word per cycle, bytes and queries alike, while the op queue is not full,
// set by the single ring write/read port; a query leaves the op queue only when the result queue has room
// reset: synchronous rst_n clears the scanner, the line counter and both queues;
// the ring needs no clearing pass, a query's result only uses slots inside the written window
`default_nettype none

`include "message_type_sniffer_ring_assert.svh"

module message_type_sniffer_ring #(
  parameter int RING_DEPTH = mtsr_pkg::RING_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  mtsr_pkg::in_word_t  in_word,
  output logic                out_empty,
  input  logic                out_pop,
  output mtsr_pkg::out_word_t out_word
);

  import mtsr_pkg::*;

  localparam int OP_W  = $bits(op_t);
  localparam int OUT_W = $bits(out_word_t);
  localparam int OCW   = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int OPCW  = $clog2(OP_FIFO_DEPTH + 1);

  logic      in_acc;
  logic      op_push, op_full, op_empty, op_pop;
  op_t       op_wr, op_rd;
  logic      out_push, out_full;
  out_word_t out_wr;
  logic [OCW-1:0]  out_count;
  logic [OPCW-1:0] op_count;

  assign in_full = op_full;
  assign in_acc  = in_push && !op_full;

  mtsr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_word (in_word),
    .op_push (op_push),
    .op_word (op_wr)
  );

  mtsr_fifo #(
    .WIDTH (OP_W),
    .DEPTH (OP_FIFO_DEPTH)
  ) u_op_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .wr_data (op_wr),
    .full    (op_full),
    .pop     (op_pop),
    .rd_data (op_rd),
    .empty   (op_empty),
    .count   (op_count)
  );

  mtsr_back #(
    .RING_DEPTH (RING_DEPTH),
    .OUT_DEPTH  (OUT_FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (!op_empty),
    .op_word   (op_rd),
    .op_pop    (op_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_word  (out_wr)
  );

  mtsr_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (out_push),
    .wr_data (out_wr),
    .full    (out_full),
    .pop     (out_pop),
    .rd_data (out_word),
    .empty   (out_empty),
    .count   (out_count)
  );

  `MTSR_ASSERT_IMPL(a_out_no_overflow, out_push, !out_full)
  `MTSR_ASSERT_NEXT(a_query_reaches_queue, op_pop && op_rd.is_query, out_push)
  `MTSR_ASSERT_IMPL(a_hit_in_window, !out_empty && out_word.hit,
                    out_word.message_seq != '0 && out_word.message_seq <= out_word.newest_seq)
  `MTSR_ASSERT_IMPL(a_full_stalls_input, in_full, op_count == OPCW'(OP_FIFO_DEPTH) && !in_acc)

endmodule

`default_nettype wire

// ----- hdl/mtsr_fifo.sv -----
`default_nettype none

module mtsr_fifo #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 4,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic [CW-1:0]    count
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = store_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mtsr_front.sv -----
`default_nettype none

module mtsr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_acc,
  input  mtsr_pkg::in_word_t in_word,
  output logic               op_push,
  output mtsr_pkg::op_t      op_word
);

  import mtsr_pkg::*;

  typedef enum logic [2:0] {
    PH_KEY,
    PH_COLON,
    PH_SPACE,
    PH_VALUE,
    PH_DONE
  } phase_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam int         KW_COUNT = 5;
  localparam logic [4:0] ALL_ALIVE = 5'b11111;

  function automatic logic [7:0] key_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = CH_QUOTE;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h79;
      3'd3:    c = 8'h70;
      3'd4:    c = 8'h65;
      3'd5:    c = CH_QUOTE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // hello, adv, sync, bis, log
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
    logic [7:0] c;
    unique case ({k, pos})
      {3'd0, 3'd0}: c = 8'h68;
      {3'd0, 3'd1}: c = 8'h65;
      {3'd0, 3'd2}: c = 8'h6C;
      {3'd0, 3'd3}: c = 8'h6C;
      {3'd0, 3'd4}: c = 8'h6F;
      {3'd1, 3'd0}: c = 8'h61;
      {3'd1, 3'd1}: c = 8'h64;
      {3'd1, 3'd2}: c = 8'h76;
      {3'd2, 3'd0}: c = 8'h73;
      {3'd2, 3'd1}: c = 8'h79;
      {3'd2, 3'd2}: c = 8'h6E;
      {3'd2, 3'd3}: c = 8'h63;
      {3'd3, 3'd0}: c = 8'h62;
      {3'd3, 3'd1}: c = 8'h69;
      {3'd3, 3'd2}: c = 8'h73;
      {3'd4, 3'd0}: c = 8'h6C;
      {3'd4, 3'd1}: c = 8'h6F;
      {3'd4, 3'd2}: c = 8'h67;
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] n;
    unique case (k)
      3'd0:    n = 3'd5;
      3'd2:    n = 3'd4;
      default: n = 3'd3;
    endcase
    return n;
  endfunction

  phase_t     phase_r, phase_nxt, s_phase;
  logic [2:0] pos_r, pos_nxt, s_pos;
  logic [4:0] alive_r, alive_nxt, s_alive;
  msg_type_t  found_r, found_nxt, s_found;

  logic [7:0] b;
  logic [2:0] v_pos_in, v_pos;
  logic [4:0] v_alive_in, v_alive;
  logic       v_hit, v_done;
  msg_type_t  v_type;
  logic       is_byte;

  assign b       = in_word.line_byte;
  assign is_byte = (in_word.kind == KIND_BYTE);

  // one step of the prefix match, from a fresh start when leaving the space phase
  always_comb begin
    v_pos_in   = (phase_r == PH_SPACE) ? 3'd0 : pos_r;
    v_alive_in = (phase_r == PH_SPACE) ? ALL_ALIVE : alive_r;
    for (int k = 0; k < KW_COUNT; k++) begin
      v_alive[k] = v_alive_in[k] && (v_pos_in < kw_len(3'(k)))
                   && (kw_char(3'(k), v_pos_in) == b);
    end
    v_pos  = v_pos_in + 3'd1;
    v_hit  = 1'b0;
    v_type = MT_UNKNOWN;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!v_hit && v_alive[k] && (kw_len(3'(k)) == v_pos)) begin
        v_hit  = 1'b1;
        v_type = msg_type_t'(3'(k + 1));
      end
    end
    v_done = v_hit || (v_alive == '0);
  end

  always_comb begin
    s_phase = phase_r;
    s_pos   = pos_r;
    s_alive = alive_r;
    s_found = found_r;
    unique case (phase_r)
      PH_KEY: begin
        if (b == key_char(pos_r)) begin
          if (pos_r == 3'd5) begin
            s_phase = PH_COLON;
            s_pos   = 3'd0;
          end else begin
            s_pos = pos_r + 3'd1;
          end
        end else begin
          s_pos = (b == CH_QUOTE) ? 3'd1 : 3'd0;
        end
      end
      PH_COLON: begin
        if (b == CH_COLON) begin
          s_phase = PH_SPACE;
        end
      end
      PH_SPACE: begin
        if (b != CH_SPACE && b != CH_TAB) begin
          s_phase = PH_VALUE;
          s_pos   = 3'd0;
          s_alive = ALL_ALIVE;
          if (b != CH_QUOTE) begin
            s_pos   = v_pos;
            s_alive = v_alive;
            if (v_done) begin
              s_phase = PH_DONE;
              s_found = v_type;
            end
          end
        end
      end
      PH_VALUE: begin
        s_pos   = v_pos;
        s_alive = v_alive;
        if (v_done) begin
          s_phase = PH_DONE;
          s_found = v_type;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    alive_nxt = alive_r;
    found_nxt = found_r;
    if (in_acc && is_byte) begin
      if (in_word.line_last) begin
        phase_nxt = PH_KEY;
        pos_nxt   = 3'd0;
        alive_nxt = ALL_ALIVE;
        found_nxt = MT_UNKNOWN;
      end else begin
        phase_nxt = s_phase;
        pos_nxt   = s_pos;
        alive_nxt = s_alive;
        found_nxt = s_found;
      end
    end
  end

  assign op_push = in_acc && (!is_byte || in_word.line_last);

  always_comb begin
    op_word.is_query     = !is_byte;
    op_word.msg_type     = (s_phase == PH_DONE) ? s_found : MT_UNKNOWN;
    op_word.arrival_time = in_word.arrival_time;
    op_word.query_seq    = in_word.query_seq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_KEY;
      pos_r   <= 3'd0;
      alive_r <= ALL_ALIVE;
      found_r <= MT_UNKNOWN;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      alive_r <= alive_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mtsr_back.sv -----
`default_nettype none

module mtsr_back #(
  parameter int  RING_DEPTH = 16,
  parameter int  OUT_DEPTH  = 4,
  localparam int CW         = $clog2(OUT_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                op_valid,
  input  mtsr_pkg::op_t       op_word,
  output logic                op_pop,
  input  logic [CW-1:0]       out_count,
  output logic                out_push,
  output mtsr_pkg::out_word_t out_word
);

  import mtsr_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);

  typedef struct packed {
    msg_type_t         msg_type;
    logic [TIME_W-1:0] arrival_time;
  } slot_t;

  slot_t ring_mem [RING_DEPTH];

  logic [SEQ_W-1:0] wcount_r, wcount_nxt;
  logic [AW-1:0]    widx_r, widx_nxt;
  logic             b_valid_r, b_valid_nxt;
  logic             b_hit_r;
  logic [SEQ_W-1:0] b_seq_r;
  logic [SEQ_W-1:0] b_newest_r;
  slot_t            rd_slot_r;

  logic             space_ok, go, do_wr, do_rd, in_win;
  logic [SEQ_W-1:0] seq_age;
  logic [AW+1:0]    diff;
  logic [AW-1:0]    rd_idx;

  // room in the result queue, counting the query already in the read stage
  assign space_ok = ({1'b0, out_count} + (CW+1)'(b_valid_r)) < (CW+1)'(OUT_DEPTH);
  assign go       = op_valid && (!op_word.is_query || space_ok);
  assign op_pop   = go;
  assign do_wr    = go && !op_word.is_query;
  assign do_rd    = go && op_word.is_query;

  // window check and slot of the asked sequence number
  always_comb begin
    seq_age = wcount_r - op_word.query_seq;
    in_win  = (op_word.query_seq != '0) && (op_word.query_seq <= wcount_r)
              && (seq_age < SEQ_W'(RING_DEPTH));
    diff    = {2'b00, widx_r} - (AW+2)'(1) - {2'b00, seq_age[AW-1:0]};
    rd_idx  = diff[AW+1] ? AW'(diff + (AW+2)'(RING_DEPTH)) : diff[AW-1:0];
  end

  always_comb begin
    wcount_nxt  = wcount_r;
    widx_nxt    = widx_r;
    b_valid_nxt = do_rd;
    if (do_wr) begin
      wcount_nxt = wcount_r + SEQ_W'(1);
      widx_nxt   = ((widx_r == AW'(RING_DEPTH - 1)) || (wcount_r == '1))
                   ? '0 : widx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcount_r  <= '0;
      widx_r    <= '0;
      b_valid_r <= 1'b0;
    end else begin
      wcount_r  <= wcount_nxt;
      widx_r    <= widx_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_rd) begin
      b_hit_r    <= in_win;
      b_seq_r    <= op_word.query_seq;
      b_newest_r <= wcount_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ring_mem[widx_r] <= '{msg_type: op_word.msg_type, arrival_time: op_word.arrival_time};
    end
    if (do_rd) begin
      rd_slot_r <= ring_mem[rd_idx];
    end
  end

  assign out_push = b_valid_r;

  always_comb begin
    out_word.hit          = b_hit_r;
    out_word.message_type = b_hit_r ? rd_slot_r.msg_type : MT_UNKNOWN;
    out_word.message_seq  = b_hit_r ? b_seq_r : '0;
    out_word.message_time = b_hit_r ? rd_slot_r.arrival_time : '0;
    out_word.newest_seq   = b_newest_r;
  end

endmodule

`default_nettype wire
